>>> src/rci_pkg.sv
package rci_pkg;

  localparam int unsigned RootW = 50;
  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned NbW = 50;
  localparam logic [31:0] MissTime = 32'hFFFF0000;
  localparam logic [31:0] TimeMax = 32'h7FFFFFFF;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_time;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic                  miss;
    logic signed [NbW-1:0] nb;
    logic [RadW-1:0]       disc;
  } front_t;

  typedef struct packed {
    logic                  valid;
    logic                  miss;
    logic signed [NbW-1:0] nb;
    logic [RootW-1:0]      root;
  } sq_t;

endpackage

>>> src/ray_circle_intersect_2d_core.sv
// Ray to circle hit test, one transfer in and one result out per clock when
// the result side keeps up. Seven arithmetic stages form the quadratic terms,
// a 50-stage square root yields one root bit per stage, and two stages pick
// the root, scale and saturate it. The whole pipeline halts while a result
// waits to be taken, so item_ready follows result_ready.
module ray_circle_intersect_2d_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rci_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rci_pkg::result_t result
);

  logic            en;
  rci_pkg::front_t front;
  rci_pkg::sq_t    sq;

  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  rci_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item       (item),
    .front      (front)
  );

  rci_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .front (front),
    .sq    (sq)
  );

  rci_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .sq           (sq),
    .result_valid (result_valid),
    .result       (result)
  );

  a_miss_time : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> result.hit_time == rci_pkg::MissTime)
    else $error("miss result carries a wrong time");

  a_hit_pos : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |-> !result.hit_time[31])
    else $error("hit result carries a negative time");

  a_reset_idle : assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

>>> src/rci_front.sv
module rci_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               item_valid,
  input  rci_pkg::item_t     item,
  output rci_pkg::front_t    front
);

  logic [6:1] v;

  logic signed [15:0] dx1, dy1;
  logic signed [32:0] vx1, vy1;
  logic [30:0]        r1;

  logic signed [48:0] pbx2, pby2;
  logic [65:0]        vxx2, vyy2;
  logic [61:0]        rr2;

  logic signed [49:0] b3;
  logic [66:0]        vv3;
  logic [61:0]        rr3;

  logic [48:0]        mb;
  logic [24:0]        hi;
  logic [23:0]        lo;
  logic [49:0]        hh4;
  logic [48:0]        hl4;
  logic [47:0]        ll4;
  logic signed [49:0] nb4;
  logic [66:0]        vv4;
  logic [61:0]        rr4;

  logic [97:0]        bb5;
  logic signed [49:0] nb5;
  logic [66:0]        vv5;
  logic [61:0]        rr5;

  logic [98:0]        lhs6, rhs6;
  logic signed [49:0] nb6;

  logic                     valid7;
  logic                     miss7;
  logic signed [49:0]       nb7;
  logic [rci_pkg::RadW-1:0] disc7;

  logic signed [65:0] sqx, sqy;

  assign sqx = vx1 * vx1;
  assign sqy = vy1 * vy1;
  assign mb  = b3[49] ? 49'(-b3) : 49'(b3);
  assign hi  = mb[48:24];
  assign lo  = mb[23:0];

  assign front = {valid7, miss7, nb7, disc7};

  always_ff @(posedge clk) begin
    if (rst) begin
      v      <= '0;
      valid7 <= 1'b0;
    end else if (en) begin
      v      <= {v[5:1], item_valid};
      valid7 <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= item.ray_dir_x;
      dy1  <= item.ray_dir_y;
      vx1  <= {item.ray_origin_x[31], item.ray_origin_x} - {item.center_x[31], item.center_x};
      vy1  <= {item.ray_origin_y[31], item.ray_origin_y} - {item.center_y[31], item.center_y};
      r1   <= item.radius;

      pbx2 <= 49'(dx1 * vx1);
      pby2 <= 49'(dy1 * vy1);
      vxx2 <= 66'(sqx);
      vyy2 <= 66'(sqy);
      rr2  <= r1 * r1;

      b3   <= {pbx2[48], pbx2} + {pby2[48], pby2};
      vv3  <= {1'b0, vxx2} + {1'b0, vyy2};
      rr3  <= rr2;

      hh4  <= hi * hi;
      hl4  <= 49'(hi * lo);
      ll4  <= lo * lo;
      nb4  <= -b3;
      vv4  <= vv3;
      rr4  <= rr3;

      bb5  <= (98'(hh4) << 48) + (98'(hl4) << 25) + 98'(ll4);
      nb5  <= nb4;
      vv5  <= vv4;
      rr5  <= rr4;

      lhs6 <= 99'(bb5) + (99'(rr5) << 28);
      rhs6 <= 99'(vv5) << 28;
      nb6  <= nb5;

      miss7 <= lhs6 < rhs6;
      disc7 <= rci_pkg::RadW'(lhs6 - rhs6);
      nb7   <= nb6;
    end
  end

endmodule

>>> src/rci_sqrt.sv
module rci_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rci_pkg::front_t front,
  output rci_pkg::sq_t    sq
);

  localparam int unsigned N = rci_pkg::RootW;
  localparam int unsigned RemW = N + 4;

  logic                             v    [0:N-1];
  logic                             miss [0:N-1];
  logic signed [rci_pkg::NbW-1:0]   nb   [0:N-1];
  logic [rci_pkg::RadW-1:0]         rad  [0:N-1];
  logic [RemW-1:0]                  rem  [0:N-1];
  logic [N-1:0]                     root [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                           v_in, miss_in;
    logic signed [rci_pkg::NbW-1:0] nb_in;
    logic [rci_pkg::RadW-1:0]       rad_in;
    logic [RemW-1:0]                rem_in, shifted, trial;
    logic [N-1:0]                   root_in;

    if (k == 0) begin : g_first
      assign v_in    = front.valid;
      assign miss_in = front.miss;
      assign nb_in   = front.nb;
      assign rad_in  = front.disc;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v[k-1];
      assign miss_in = miss[k-1];
      assign nb_in   = nb[k-1];
      assign rad_in  = rad[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
    end

    assign shifted = {rem_in[RemW-3:0], rad_in[rci_pkg::RadW-1 -: 2]};
    assign trial   = RemW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        miss[k] <= miss_in;
        nb[k]   <= nb_in;
        rad[k]  <= rad_in << 2;
        if (shifted >= trial) begin
          rem[k]  <= shifted - trial;
          root[k] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem[k]  <= shifted;
          root[k] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign sq.valid = v[N-1];
  assign sq.miss  = miss[N-1];
  assign sq.nb    = nb[N-1];
  assign sq.root  = root[N-1];

endmodule

>>> src/rci_back.sv
module rci_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  rci_pkg::sq_t     sq,
  output logic             result_valid,
  output rci_pkg::result_t result
);

  logic               v1, miss1;
  logic signed [51:0] tn1, tf1;
  logic signed [51:0] t;
  logic               hit_next;
  logic [37:0]        q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= sq.valid;
      result_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss1 <= sq.miss;
      tn1   <= {{2{sq.nb[49]}}, sq.nb} - {2'b00, sq.root};
      tf1   <= {{2{sq.nb[49]}}, sq.nb} + {2'b00, sq.root};
    end
  end

  always_comb begin
    hit_next = 1'b0;
    t        = tf1;
    if (!miss1) begin
      if (tn1 > 0) begin
        hit_next = 1'b1;
        t        = tn1;
      end else if (tf1 > 0) begin
        hit_next = 1'b1;
      end
    end
    q = t[51:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.hit <= hit_next;
      if (!hit_next) begin
        result.hit_time <= rci_pkg::MissTime;
      end else if (|q[37:31]) begin
        result.hit_time <= rci_pkg::TimeMax;
      end else begin
        result.hit_time <= {1'b0, q[30:0]};
      end
    end
  end

endmodule

>>> sim/ray_circle_intersect_2d_core_tb.sv
module ray_circle_intersect_2d_core_tb;

  localparam int NumRandom = 2000;
  localparam int QuietTail = 300;
  localparam int DrainAt = 900;
  localparam int StallLimit = 5000;
  localparam real TwoPi = 6.283185307179586;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  rci_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  rci_pkg::result_t result;

  rci_pkg::item_t   pending_items[$];
  rci_pkg::result_t expected_results[$];
  int      accepted_items = 0;
  int      checked_results = 0;
  int      hits_seen = 0;
  int      misses_seen = 0;
  int      mismatches = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      quiet_cycles = 0;
  bit      drained_once = 1'b0;

  ray_circle_intersect_2d_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rci_pkg::result_t intersect_ray(rci_pkg::item_t it);
    logic signed [63:0]  vx, vy, b, s, t_near, t_far, t;
    logic signed [127:0] bw, vxw, vyw;
    logic [127:0]        rw, lhs, rhs, disc, root, cand;
    logic [63:0]         q;
    rci_pkg::result_t    res;
    vx = it.ray_origin_x - it.center_x;
    vy = it.ray_origin_y - it.center_y;
    b = it.ray_dir_x * vx + it.ray_dir_y * vy;
    bw = b;
    vxw = vx;
    vyw = vy;
    rw = it.radius;
    lhs = bw * bw + ((rw * rw) << 28);
    rhs = (vxw * vxw + vyw * vyw) << 28;
    res.hit = 1'b0;
    res.hit_time = rci_pkg::MissTime;
    if (lhs < rhs) return res;
    disc = lhs - rhs;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= disc) root = cand;
    end
    s = root[63:0];
    t_near = -b - s;
    t_far = -b + s;
    if (t_near > 0) t = t_near;
    else if (t_far > 0) t = t_far;
    else return res;
    q = t >>> 14;
    if (q > 64'(rci_pkg::TimeMax)) q = 64'(rci_pkg::TimeMax);
    res.hit = 1'b1;
    res.hit_time = q[31:0];
    return res;
  endfunction

  task automatic add_ray(logic [31:0] ox, logic [31:0] oy, logic [15:0] dx, logic [15:0] dy,
                         logic [31:0] cx, logic [31:0] cy, logic [30:0] r);
    rci_pkg::item_t it;
    it.ray_origin_x = ox;
    it.ray_origin_y = oy;
    it.ray_dir_x = dx;
    it.ray_dir_y = dy;
    it.center_x = cx;
    it.center_y = cy;
    it.radius = r;
    pending_items.push_back(it);
  endtask

  task automatic add_random_ray();
    real            ang;
    int             span;
    logic [223:0]   raw;
    rci_pkg::item_t it;
    if ($urandom_range(99) < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(rci_pkg::item_t)-1:0];
      pending_items.push_back(it);
    end else begin
      span = 1 << $urandom_range(26, 14);
      ang = TwoPi * $urandom_range(359999) / 360000.0;
      it.ray_dir_x = 16'($rtoi($cos(ang) * 16384.0));
      it.ray_dir_y = 16'($rtoi($sin(ang) * 16384.0));
      it.ray_origin_x = $signed($urandom_range(2 * span)) - span;
      it.ray_origin_y = $signed($urandom_range(2 * span)) - span;
      it.center_x = $signed($urandom_range(2 * span)) - span;
      it.center_y = $signed($urandom_range(2 * span)) - span;
      it.radius = 31'($urandom_range(span));
      pending_items.push_back(it);
    end
  endtask

  initial begin
    add_ray(0, 0, 16384, 0, 10 << 16, 0, 2 << 16);
    add_ray(0, 0, 16384, 0, 0, 0, 5 << 16);
    add_ray(0, 0, 16384, 0, -(10 << 16), 0, 2 << 16);
    add_ray(0, 0, 16384, 0, 10 << 16, 5 << 16, 2 << 16);
    add_ray(0, 0, 16384, 0, 10 << 16, 2 << 16, 2 << 16);
    add_ray(0, 0, 0, 0, 0, 0, 3 << 16);
    add_ray(0, 0, 0, 0, 10 << 16, 0, 3 << 16);
    add_ray(0, 0, 16384, 16384, 10 << 16, 10 << 16, 2 << 16);
    add_ray(0, 0, 16384, 0, 5 << 16, 0, (5 << 16) - 1);
    add_ray(0, 0, 16384, 0, 5 << 16, 0, 5 << 16);
    add_ray(0, 0, 16385, 0, 5 << 16, 0, 5 << 16);
    add_ray(32'h80000000, 0, 16384, 0, 32'h7FFFFFFF, 0, 1 << 16);
    add_ray(32'h80000000, 32'h80000000, -16384, -16384, 32'h7FFFFFFF, 32'h7FFFFFFF,
            31'h7FFFFFFF);
    add_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 32'h80000000, 32'h80000000,
            31'h7FFFFFFF);
    add_ray(32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h8000, 32'h80000000, 32'h7FFFFFFF,
            31'h7FFFFFFF);
    add_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            31'h7FFFFFFF);
    add_ray(0, 0, 0, -16384, 0, -(7 << 16), 1 << 16);
    add_ray(0, 0, -16384, 0, 0, 0, 0);
    add_ray(0, 0, 16384, 0, 0, 0, 0);
    add_ray(0, 0, 16384, 0, 3 << 16, 0, 0);
    for (int i = 0; i < NumRandom; i++) add_random_ray();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("Checked %0d results: %0d hits and %0d misses.", checked_results,
             hits_seen, misses_seen);
    $display("%0d mismatches, sender held once until the pipeline drained.", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin
    bit take;
    bit hold;
    take = item_valid && item_ready;
    if (!rst) begin
      if (take) begin
        expected_results.push_back(intersect_ray(item));
        accepted_items++;
      end
      if (!item_valid || take) begin
        hold = (accepted_items >= DrainAt && !drained_once);
        if (hold && expected_results.size() == 0 && !take) drained_once = 1'b1;
        if (send_idle > 0) begin
          send_idle--;
          item_valid <= 1'b0;
        end else if (pending_items.size() == 0 || hold) begin
          item_valid <= 1'b0;
        end else begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
          if (pending_items.size() > QuietTail && $urandom_range(99) < 8)
            send_idle = $urandom_range(9, 1);
        end
      end
    end
  end

  always @(posedge clk) begin
    rci_pkg::result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        checked_results++;
        if (result.hit) hits_seen++;
        else misses_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transfer: %p", result);
        end else begin
          want = expected_results.pop_front();
          if (result.hit !== want.hit || result.hit_time !== want.hit_time) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected hit=%0b time=%0d, got hit=%0b time=%0d",
                       want.hit, want.hit_time, result.hit, result.hit_time);
          end
        end
      end
      if (recv_idle > 0) begin
        recv_idle--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (pending_items.size() > QuietTail && $urandom_range(99) < 8)
          recv_idle = $urandom_range(9, 1);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Watchdog expired with %0d results outstanding.", expected_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
src/rci_pkg.sv
src/rci_front.sv
src/rci_sqrt.sv
src/rci_back.sv
src/ray_circle_intersect_2d_core.sv
sim/ray_circle_intersect_2d_core_tb.sv
